>>> hw/rtl/rqe_pkg.sv
// ============================================================================
// rqe_pkg
// Shared types, constants and CORDIC helpers for the relative quaternion to
// Euler angle pipeline.
// ============================================================================
package rqe_pkg;

    // Default number of CORDIC iterations and the table limit
    localparam int CORDIC_STEPS_DEF = 16;
    localparam int STEP_LIMIT       = 24;

    // Field widths
    localparam int QW  = 16;   // input component, Q2.14
    localparam int PW  = 32;   // first products, Q4.28
    localparam int SW  = 35;   // raw product quaternion components
    localparam int MW  = 34;   // magnitude of a raw component
    localparam int LW  = 6;    // bit length of the magnitude
    localparam int NW  = 32;   // normalized component
    localparam int EW  = 64;   // second products and their sums
    localparam int CW  = 36;   // CORDIC x and y
    localparam int AW  = 28;   // CORDIC angle, 2^-24 rad
    localparam int GW  = 32;   // gain constant
    localparam int OW  = 16;   // roll and yaw
    localparam int OPW = 15;   // pitch
    localparam int RW  = AW - 11;  // rounded angle before saturation

    localparam int NORM_BITS = 30;
    localparam int DN_SHIFT  = 33;
    localparam int GAIN_SH   = 30;

    localparam logic signed [AW-1:0] HALF_PI_Q24 = 28'sd26353589;
    localparam logic signed [AW-1:0] ROUND_HALF  = 28'sd1024;
    localparam logic signed [GW-1:0] GAIN_Q30    = 32'sd1768195363;
    localparam logic signed [RW-1:0] LIM_WIDE    = 17'sd25736;
    localparam logic signed [RW-1:0] LIM_PITCH   = 17'sd12868;

    // One CORDIC vectoring state
    typedef struct packed {
        logic signed [CW-1:0] x;
        logic signed [CW-1:0] y;
        logic signed [AW-1:0] ang;
        logic                 zero;
    } t_cv;

    // Arctangent of 2^-i in 2^-24 rad
    function automatic logic signed [AW-1:0] atan_q24(input int i);
        logic signed [AW-1:0] v;
        case (i)
            0:  v = 28'sd13176795;
            1:  v = 28'sd7778716;
            2:  v = 28'sd4110060;
            3:  v = 28'sd2086331;
            4:  v = 28'sd1047214;
            5:  v = 28'sd524117;
            6:  v = 28'sd262123;
            7:  v = 28'sd131069;
            8:  v = 28'sd65536;
            9:  v = 28'sd32768;
            10: v = 28'sd16384;
            11: v = 28'sd8192;
            12: v = 28'sd4096;
            13: v = 28'sd2048;
            14: v = 28'sd1024;
            15: v = 28'sd512;
            16: v = 28'sd256;
            17: v = 28'sd128;
            18: v = 28'sd64;
            19: v = 28'sd32;
            20: v = 28'sd16;
            21: v = 28'sd8;
            22: v = 28'sd4;
            23: v = 28'sd2;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Rotate into the right half plane by a quarter turn when x is negative
    function automatic t_cv prerot(input logic signed [CW-1:0] x,
                                   input logic signed [CW-1:0] y);
        t_cv c;
        c.zero = (x == '0) && (y == '0);
        c.x    = x;
        c.y    = y;
        c.ang  = '0;
        if (x < 0) begin
            if (y >= 0) begin
                c.x   = y;
                c.y   = -x;
                c.ang = HALF_PI_Q24;
            end else begin
                c.x   = -y;
                c.y   = x;
                c.ang = -HALF_PI_Q24;
            end
        end
        return c;
    endfunction

    // One vectoring iteration, driving y toward zero
    function automatic t_cv cstep(input t_cv c, input int i);
        t_cv                  r;
        logic signed [CW-1:0] dx;
        logic signed [CW-1:0] dy;
        dx = c.y >>> i;
        dy = c.x >>> i;
        r  = c;
        if (c.y >= 0) begin
            r.x   = c.x + dx;
            r.y   = c.y - dy;
            r.ang = c.ang + atan_q24(i);
        end else begin
            r.x   = c.x - dx;
            r.y   = c.y + dy;
            r.ang = c.ang - atan_q24(i);
        end
        return r;
    endfunction

    // Round 2^-24 rad to Q3.13 and saturate to +-lim
    function automatic logic signed [RW-1:0] to_q13(input logic signed [AW-1:0] z,
                                                    input logic signed [RW-1:0] lim);
        logic signed [AW-1:0] t;
        logic signed [RW-1:0] q;
        t = (z + ROUND_HALF) >>> 11;
        q = t[RW-1:0];
        if (q > lim) begin
            q = lim;
        end else if (q < -lim) begin
            q = -lim;
        end
        return q;
    endfunction

endpackage

>>> hw/rtl/relative_quaternion_to_euler_top.sv
// ============================================================================
// relative_quaternion_to_euler_top
// Relative rotation conj(ref)*tgt of two Q2.14 quaternions, reported as
// roll, pitch and yaw in Q3.13 radians through pipelined CORDIC vectoring.
// ============================================================================
//  channel  | dir | contents
//  ---------+-----+--------------------------------------------------------
//  s_*      | in  | ref w,x,y,z then tgt w,x,y,z, 16 bits each, signed
//  m_*      | out | roll(16), pitch(15), yaw(16); tuser = degenerate flag
//
//  One request enters per cycle while the output is not stalled. The depth
//  is set by the two CORDIC chains in series: pitch vectoring needs the
//  magnitude that the roll chain leaves.
//  Reset clears only the valid bits. A stall on the output freezes the whole
//  pipeline; an empty output register still lets requests in.
module relative_quaternion_to_euler_top #(
    parameter int CORDIC_STEPS = rqe_pkg::CORDIC_STEPS_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // ref_w, ref_x, ref_y, ref_z, tgt_w, tgt_x, tgt_y, tgt_z (16 bits each)
    input  logic [127:0] i_s_tdata,
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // roll [15:0], pitch [30:16], yaw [46:31], zero [47]
    output logic [47:0]  o_m_tdata,
    // degenerate
    output logic         o_m_tuser
);

    localparam int STEPS = (CORDIC_STEPS > rqe_pkg::STEP_LIMIT) ?
                           rqe_pkg::STEP_LIMIT : CORDIC_STEPS;
    localparam int C0    = 9;               // stage of the first CORDIC state
    localparam int P0    = C0 + STEPS + 1;  // stage of the pitch prerotation
    localparam int L     = P0 + STEPS + 2;  // total depth

    localparam int QW  = rqe_pkg::QW;
    localparam int PW  = rqe_pkg::PW;
    localparam int SW  = rqe_pkg::SW;
    localparam int MW  = rqe_pkg::MW;
    localparam int LW  = rqe_pkg::LW;
    localparam int NW  = rqe_pkg::NW;
    localparam int EW  = rqe_pkg::EW;
    localparam int CW  = rqe_pkg::CW;
    localparam int AW  = rqe_pkg::AW;
    localparam int GW  = rqe_pkg::GW;
    localparam int RW  = rqe_pkg::RW;

    // Pipeline advance and valid bits
    logic         w_en;
    logic [L-1:0] r_vld;
    logic [L-1:0] r_deg;

    assign w_en       = !r_vld[L-1] || i_m_tready;
    assign o_s_tready = w_en;
    assign o_m_tvalid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_s_tvalid};
        end
    end

    // Stage 1: capture components, flag zero-length inputs
    logic signed [QW-1:0] r_q [0:7];
    logic                 n_deg;

    assign n_deg = (i_s_tdata[63:0] == '0) || (i_s_tdata[127:64] == '0);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 8; k++) begin
                r_q[k] <= i_s_tdata[k*QW +: QW];
            end
            r_deg <= {r_deg[L-2:0], n_deg};
        end
    end

    // Stage 2: the sixteen first products
    logic signed [PW-1:0] r_p [0:15];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_p[0]  <= r_q[0] * r_q[4];
            r_p[1]  <= r_q[1] * r_q[5];
            r_p[2]  <= r_q[2] * r_q[6];
            r_p[3]  <= r_q[3] * r_q[7];
            r_p[4]  <= r_q[0] * r_q[5];
            r_p[5]  <= r_q[1] * r_q[4];
            r_p[6]  <= r_q[2] * r_q[7];
            r_p[7]  <= r_q[3] * r_q[6];
            r_p[8]  <= r_q[0] * r_q[6];
            r_p[9]  <= r_q[2] * r_q[4];
            r_p[10] <= r_q[3] * r_q[5];
            r_p[11] <= r_q[1] * r_q[7];
            r_p[12] <= r_q[0] * r_q[7];
            r_p[13] <= r_q[3] * r_q[4];
            r_p[14] <= r_q[1] * r_q[6];
            r_p[15] <= r_q[2] * r_q[5];
        end
    end

    // Stage 3: relative quaternion components
    logic signed [SW-1:0] r_c [0:3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c[0] <= SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]) + SW'(r_p[3]);
            r_c[1] <= SW'(r_p[4]) - SW'(r_p[5]) - (SW'(r_p[6]) - SW'(r_p[7]));
            r_c[2] <= SW'(r_p[8]) - SW'(r_p[9]) - (SW'(r_p[10]) - SW'(r_p[11]));
            r_c[3] <= SW'(r_p[12]) - SW'(r_p[13]) - (SW'(r_p[14]) - SW'(r_p[15]));
        end
    end

    // Stage 4: largest magnitude
    logic signed [SW-1:0] r_c4 [0:3];
    logic        [MW-1:0] r_mx;
    logic        [MW-1:0] n_mx;
    always_comb begin
        logic [SW-1:0] a;
        n_mx = '0;
        for (int k = 0; k < 4; k++) begin
            a = r_c[k][SW-1] ? -r_c[k] : r_c[k];
            if (a[MW-1:0] > n_mx) begin
                n_mx = a[MW-1:0];
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c4 <= r_c;
            r_mx <= n_mx;
        end
    end

    // Stage 5: bit length of the largest magnitude
    logic signed [SW-1:0] r_c5 [0:3];
    logic        [LW-1:0] r_len;
    logic        [LW-1:0] n_len;
    always_comb begin
        n_len = '0;
        for (int k = 0; k < MW; k++) begin
            if (r_mx[k]) begin
                n_len = LW'(k + 1);
            end
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_c5  <= r_c4;
            r_len <= n_len;
        end
    end

    // Stage 6: scale so the largest component has 30 bits of magnitude
    logic signed [NW-1:0] r_v [0:3];
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < 4; k++) begin
                if (r_len > LW'(rqe_pkg::NORM_BITS)) begin
                    r_v[k] <= NW'(r_c5[k] >>> (r_len - LW'(rqe_pkg::NORM_BITS)));
                end else begin
                    r_v[k] <= NW'(r_c5[k] <<< (LW'(rqe_pkg::NORM_BITS) - r_len));
                end
            end
        end
    end

    // Stage 7: second products (w,x,y,z = r_v[0..3])
    logic signed [EW-1:0] r_ww, r_xx, r_yy, r_zz, r_wx, r_yz, r_wz, r_xy, r_wy, r_zx;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ww <= EW'(r_v[0] * r_v[0]);
            r_xx <= EW'(r_v[1] * r_v[1]);
            r_yy <= EW'(r_v[2] * r_v[2]);
            r_zz <= EW'(r_v[3] * r_v[3]);
            r_wx <= EW'(r_v[0] * r_v[1]);
            r_yz <= EW'(r_v[2] * r_v[3]);
            r_wz <= EW'(r_v[0] * r_v[3]);
            r_xy <= EW'(r_v[1] * r_v[2]);
            r_wy <= EW'(r_v[0] * r_v[2]);
            r_zx <= EW'(r_v[3] * r_v[1]);
        end
    end

    // Stage 8: norm, numerators and denominators
    logic signed [EW-1:0] r_n, r_a, r_b, r_cc, r_d, r_s;
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n  <= r_ww + r_xx + r_yy + r_zz;
            r_a  <= (r_wx + r_yz) <<< 1;
            r_b  <= r_ww - r_xx - r_yy + r_zz;
            r_cc <= (r_wz + r_xy) <<< 1;
            r_d  <= r_ww + r_xx - r_yy - r_zz;
            r_s  <= (r_wy - r_zx) <<< 1;
        end
    end

    // Stage 9: clamp the asin argument, drop 33 bits, clamp again
    logic signed [CW-1:0] r_n9, r_a9, r_b9, r_c9, r_d9, r_s9;
    logic signed [EW-1:0] w_s1, w_n1, w_s2;
    always_comb begin
        w_s1 = r_s;
        if (w_s1 > r_n) begin
            w_s1 = r_n;
        end else if (w_s1 < -r_n) begin
            w_s1 = -r_n;
        end
        w_n1 = r_n >>> rqe_pkg::DN_SHIFT;
        w_s2 = w_s1 >>> rqe_pkg::DN_SHIFT;
        if (w_s2 > w_n1) begin
            w_s2 = w_n1;
        end else if (w_s2 < -w_n1) begin
            w_s2 = -w_n1;
        end
    end
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_n9 <= CW'(w_n1);
            r_a9 <= CW'(r_a >>> rqe_pkg::DN_SHIFT);
            r_b9 <= CW'(r_b >>> rqe_pkg::DN_SHIFT);
            r_c9 <= CW'(r_cc >>> rqe_pkg::DN_SHIFT);
            r_d9 <= CW'(r_d >>> rqe_pkg::DN_SHIFT);
            r_s9 <= CW'(w_s2);
        end
    end

    // Stage 10: quadrant prerotation for roll and yaw, gain on the asin term
    rqe_pkg::t_cv         r_rc [0:STEPS];
    rqe_pkg::t_cv         r_yc [0:STEPS];
    logic signed [CW-1:0] r_sg [0:STEPS];
    logic signed [GW-1:0] w_s32;
    logic signed [EW-1:0] w_sgp;

    // The clamped asin term stays below 2^30 in magnitude, so 32 bits hold it
    assign w_s32 = r_s9[GW-1:0];
    assign w_sgp = EW'(w_s32 * rqe_pkg::GAIN_Q30);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rc[0] <= rqe_pkg::prerot(r_b9, r_a9);
            r_yc[0] <= rqe_pkg::prerot(r_d9, r_c9);
            r_sg[0] <= CW'(w_sgp >>> rqe_pkg::GAIN_SH);
        end
    end

    // Roll and yaw CORDIC iterations, one per stage
    for (genvar g = 0; g < STEPS; g++) begin : g_ry
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_rc[g+1] <= rqe_pkg::cstep(r_rc[g], g);
                r_yc[g+1] <= rqe_pkg::cstep(r_yc[g], g);
                r_sg[g+1] <= r_sg[g];
            end
        end
    end

    // Pitch prerotation against the roll magnitude; settle roll and yaw
    rqe_pkg::t_cv         r_pc [0:STEPS];
    logic signed [AW-1:0] r_zr [0:STEPS];
    logic signed [AW-1:0] r_zy [0:STEPS];
    logic signed [CW-1:0] w_mg;

    assign w_mg = r_rc[STEPS].zero ? '0 : r_rc[STEPS].x;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_pc[0] <= rqe_pkg::prerot(w_mg, r_sg[STEPS]);
            r_zr[0] <= r_rc[STEPS].zero ? '0 : r_rc[STEPS].ang;
            r_zy[0] <= r_yc[STEPS].zero ? '0 : r_yc[STEPS].ang;
        end
    end

    // Pitch CORDIC iterations
    for (genvar g = 0; g < STEPS; g++) begin : g_p
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_pc[g+1] <= rqe_pkg::cstep(r_pc[g], g);
                r_zr[g+1] <= r_zr[g];
                r_zy[g+1] <= r_zy[g];
            end
        end
    end

    // Output register: round, saturate, force zero on degenerate input
    logic signed [RW-1:0] w_roll, w_pitch, w_yaw;
    logic        [47:0]   r_out;

    assign w_roll  = rqe_pkg::to_q13(r_zr[STEPS], rqe_pkg::LIM_WIDE);
    assign w_yaw   = rqe_pkg::to_q13(r_zy[STEPS], rqe_pkg::LIM_WIDE);
    assign w_pitch = rqe_pkg::to_q13(r_pc[STEPS].zero ? '0 : r_pc[STEPS].ang,
                                     rqe_pkg::LIM_PITCH);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            if (r_deg[L-2]) begin
                r_out <= '0;
            end else begin
                r_out <= {1'b0, w_yaw[rqe_pkg::OW-1:0], w_pitch[rqe_pkg::OPW-1:0],
                          w_roll[rqe_pkg::OW-1:0]};
            end
        end
    end

    assign o_m_tdata = r_out;
    assign o_m_tuser = r_deg[L-1];

    // Checks on the output stage
    a_deg_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && o_m_tuser |-> o_m_tdata == '0)
        else $error("degenerate result carries nonzero angles");

    a_pitch_lim : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[30:16]) <= 15'sd12868 &&
                        $signed(o_m_tdata[30:16]) >= -15'sd12868))
        else $error("pitch beyond saturation limit");

    a_roll_lim : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> ($signed(o_m_tdata[15:0]) <= 16'sd25736 &&
                        $signed(o_m_tdata[15:0]) >= -16'sd25736))
        else $error("roll beyond saturation limit");

    a_ready_free : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty output register");

endmodule

>>> tb/relative_quaternion_to_euler_top_test.sv
`timescale 1ns / 100ps
// ============================================================================
// relative_quaternion_to_euler_top_test
// Streams pairs of reference and target quaternions into the block and checks
// each roll, pitch, yaw and degenerate flag against a bit-exact predictor of
// the fixed-point CORDIC datapath, under random idling and output stalls.
// ============================================================================
module relative_quaternion_to_euler_top_test;

    localparam int NUM_RAND   = 1500;
    localparam int MAX_STEPS  = 24;
    localparam int HOLD_LEN   = 300;
    localparam int DRAIN_WAIT = 80;
    localparam longint HALF_PI = 64'sd26353589;
    localparam longint GAIN    = 64'sd1768195363;
    localparam longint LIM_RY  = 64'sd25736;
    localparam longint LIM_P   = 64'sd12868;

    typedef struct packed {
        logic [15:0] roll;
        logic [14:0] pitch;
        logic [15:0] yaw;
        logic        degen;
    } t_angles;

    typedef struct {
        logic [127:0] data;
        bit           known;
        t_angles      want;
    } t_row;

    logic         i_clk;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    // ref_w, ref_x, ref_y, ref_z, tgt_w, tgt_x, tgt_y, tgt_z (16 bits each)
    logic [127:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    // roll [15:0], pitch [30:16], yaw [46:31], zero [47]
    logic [47:0]  o_m_tdata;
    // degenerate
    logic         o_m_tuser;

    t_angles angle_q[$];
    int      mismatches;
    int      results_seen;
    int      degen_seen;
    int      snd_idle;
    int      rcv_idle;
    bit      hold_go;
    bit      hold_done;

    longint atan_q24[MAX_STEPS] = '{
        13176795, 7778716, 4110060, 2086331, 1047214, 524117, 262123, 131069,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    relative_quaternion_to_euler_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser)
    );

    // CORDIC vectoring: angle of (x, y) in 2^-24 rad, gained magnitude in mag
    function automatic longint vector_angle(input longint x, input longint y,
                                            output longint mag);
        longint ang;
        longint t;
        longint dx;
        longint dy;
        int     steps;
        steps = (rqe_pkg::CORDIC_STEPS_DEF > MAX_STEPS) ? MAX_STEPS
                                                         : rqe_pkg::CORDIC_STEPS_DEF;
        ang = 0;
        if (x == 0 && y == 0) begin
            mag = 0;
            return 0;
        end
        if (x < 0) begin
            t = x;
            if (y >= 0) begin
                x = y;  y = -t; ang = HALF_PI;
            end else begin
                x = -y; y = t;  ang = -HALF_PI;
            end
        end
        for (int i = 0; i < steps; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x += dx; y -= dy; ang += atan_q24[i];
            end else begin
                x -= dx; y += dy; ang -= atan_q24[i];
            end
        end
        mag = x;
        return ang;
    endfunction

    // Round 2^-24 rad to Q3.13 with saturation
    function automatic longint round_q13(input longint z, input longint lim);
        longint q;
        q = (z + 1024) >>> 11;
        if (q > lim) q = lim;
        if (q < -lim) q = -lim;
        return q;
    endfunction

    function automatic longint mag_of(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Euler angles of conj(ref) * tgt
    function automatic t_angles relative_euler(input logic [127:0] d);
        longint  c[8];
        longint  w, x, y, z, mx, n, a, b, cc, dd, s, mg, unused;
        int      len;
        t_angles r;
        for (int k = 0; k < 8; k++)
            c[k] = longint'($signed(d[16*k +: 16]));
        r = '0;
        if ((c[0] | c[1] | c[2] | c[3]) == 0 || (c[4] | c[5] | c[6] | c[7]) == 0) begin
            r.degen = 1'b1;
            return r;
        end
        w = c[0]*c[4] + c[1]*c[5] + c[2]*c[6] + c[3]*c[7];
        x = c[0]*c[5] - c[1]*c[4] - (c[2]*c[7] - c[3]*c[6]);
        y = c[0]*c[6] - c[2]*c[4] - (c[3]*c[5] - c[1]*c[7]);
        z = c[0]*c[7] - c[3]*c[4] - (c[1]*c[6] - c[2]*c[5]);
        mx = mag_of(w);
        if (mag_of(x) > mx) mx = mag_of(x);
        if (mag_of(y) > mx) mx = mag_of(y);
        if (mag_of(z) > mx) mx = mag_of(z);
        len = 0;
        while (len < 40 && (mx >> len) != 0)
            len++;
        // bring the largest component to 30 bits of magnitude
        if (len > 30) begin
            w = w >>> (len - 30); x = x >>> (len - 30);
            y = y >>> (len - 30); z = z >>> (len - 30);
        end else begin
            w = w <<< (30 - len); x = x <<< (30 - len);
            y = y <<< (30 - len); z = z <<< (30 - len);
        end
        n  = w*w + x*x + y*y + z*z;
        a  = 2 * (w*x + y*z);
        b  = w*w - x*x - y*y + z*z;
        cc = 2 * (w*z + x*y);
        dd = w*w + x*x - y*y - z*z;
        s  = 2 * (w*y - z*x);
        if (s > n) s = n;
        if (s < -n) s = -n;
        n = n >>> 33; a = a >>> 33; b = b >>> 33;
        cc = cc >>> 33; dd = dd >>> 33; s = s >>> 33;
        if (s > n) s = n;
        if (s < -n) s = -n;
        r.roll  = 16'(round_q13(vector_angle(b, a, mg), LIM_RY));
        r.yaw   = 16'(round_q13(vector_angle(dd, cc, unused), LIM_RY));
        r.pitch = 15'(round_q13(vector_angle(mg, (s * GAIN) >>> 30, unused), LIM_P));
        return r;
    endfunction

    function automatic logic [127:0] pack_pair(input int rw, rx, ry, rz, tw, tx, ty, tz);
        return {16'(tz), 16'(ty), 16'(tx), 16'(tw), 16'(rz), 16'(ry), 16'(rx), 16'(rw)};
    endfunction

    // Pick one component: mostly random, sometimes an extreme value
    function automatic int pick_comp();
        case ($urandom_range(7))
            0:       return -32768;
            1:       return 32767;
            2:       return $urandom_range(2) - 1;
            default: return $signed(16'($urandom));
        endcase
    endfunction

    function automatic logic [127:0] random_pair();
        logic [127:0] d;
        for (int k = 0; k < 8; k++)
            d[16*k +: 16] = ($urandom_range(3) == 0) ? 16'(pick_comp()) : 16'($urandom);
        // now and then one side has zero length
        case ($urandom_range(29))
            0:       d[63:0]   = '0;
            1:       d[127:64] = '0;
            default: ;
        endcase
        return d;
    endfunction

    // Offer one request and hold it until accepted; log its expectation
    task automatic send_request(input logic [127:0] d, input bit known, input t_angles want);
        if (snd_idle > 0 && $urandom_range(99) < snd_idle) begin
            i_s_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= d;
        do @(posedge i_clk); while (!o_s_tready);
        angle_q.push_back(known ? want : relative_euler(d));
    endtask

    task automatic wait_drained();
        i_s_tvalid <= 1'b0;
        while (angle_q.size() != 0) @(posedge i_clk);
    endtask

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Limit on the whole run
    initial begin
        #5000000;
        $display("relative_quaternion_to_euler_top regression: fail");
        $finish;
    end

    // Receiver: stall at random, hold off on request, check each result
    initial begin
        t_angles want;
        t_angles got;
        int      hold_cnt;
        hold_cnt   = 0;
        i_m_tready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_m_tvalid && i_m_tready) begin
                got = {o_m_tdata[15:0], o_m_tdata[30:16], o_m_tdata[46:31], o_m_tuser};
                results_seen++;
                degen_seen += o_m_tuser;
                if (angle_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result %h / %b", o_m_tdata, o_m_tuser);
                end else begin
                    want = angle_q.pop_front();
                    if (got !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: roll %0d/%0d pitch %0d/%0d yaw %0d/%0d deg %b/%b",
                                     $signed(want.roll), $signed(got.roll),
                                     $signed(want.pitch), $signed(got.pitch),
                                     $signed(want.yaw), $signed(got.yaw),
                                     want.degen, got.degen);
                    end
                end
            end
            if (hold_go && !hold_done && hold_cnt == 0) begin
                hold_cnt  = HOLD_LEN;
                hold_done = 1'b1;
            end
            if (hold_cnt > 0) begin
                hold_cnt--;
                i_m_tready <= 1'b0;
            end else begin
                i_m_tready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Sender: reset, directed table, then random phases
    initial begin
        t_row    rows[$];
        t_row    row;
        t_angles none;
        int      wait_cnt;
        none         = '0;
        mismatches   = 0;
        results_seen = 0;
        degen_seen   = 0;
        snd_idle     = 0;
        rcv_idle     = 0;
        hold_go      = 1'b0;
        hold_done    = 1'b0;
        i_rst_n      = 1'b0;
        i_s_tvalid   = 1'b0;
        i_s_tdata    = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // identity to identity, and zero-length sides
        rows.push_back('{pack_pair(16384, 0, 0, 0, 16384, 0, 0, 0), 1, '{0, 0, 0, 0}});
        rows.push_back('{pack_pair(0, 0, 0, 0, 16384, 0, 0, 0), 1, '{0, 0, 0, 1}});
        rows.push_back('{pack_pair(16384, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1}});
        rows.push_back('{pack_pair(0, 0, 0, 0, 0, 0, 0, 0), 1, '{0, 0, 0, 1}});
        rows.push_back('{pack_pair(0, 0, 0, 0, -32768, 32767, -32768, 32767), 1,
                         '{0, 0, 0, 1}});
        // extremes of every component
        rows.push_back('{pack_pair(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768), 0, none});
        rows.push_back('{pack_pair(32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767), 0, none});
        rows.push_back('{pack_pair(32767, -32768, 32767, -32768,
                                   -32768, 32767, -32768, 32767), 0, none});
        rows.push_back('{pack_pair(1, 0, 0, 0, 0, 0, 0, -1), 0, none});
        // quarter turns about each axis, half turns about x and z, the asin clamp at pitch +-90
        rows.push_back('{pack_pair(16384, 0, 0, 0, 11585, 11585, 0, 0), 0, none});
        rows.push_back('{pack_pair(16384, 0, 0, 0, 11585, 0, 11585, 0), 0, none});
        rows.push_back('{pack_pair(16384, 0, 0, 0, 11585, 0, -11585, 0), 0, none});
        rows.push_back('{pack_pair(16384, 0, 0, 0, 11585, 0, 0, 11585), 0, none});
        rows.push_back('{pack_pair(16384, 0, 0, 0, 0, 16384, 0, 0), 0, none});
        rows.push_back('{pack_pair(16384, 0, 0, 0, 0, 0, 0, -16384), 0, none});
        rows.push_back('{pack_pair(1, 0, 1, 0, 1, 0, 0, 0), 0, none});
        rows.push_back('{pack_pair(0, 1, 0, 0, 0, 0, 1, 0), 0, none});
        rows.push_back('{pack_pair(-16384, 0, 0, 0, 16384, 0, 0, 0), 0, none});
        rows.push_back('{pack_pair(3, -7, 11, -5, 2, 9, -4, 6), 0, none});

        snd_idle = 18;
        rcv_idle = 51;
        foreach (rows[k]) begin
            row = rows[k];
            send_request(row.data, row.known, row.want);
        end

        for (int phase = 0; phase < 3; phase++) begin
            // pause until every result is back before changing the pace
            wait_drained();
            snd_idle = (phase == 0) ? 18 : (phase == 1) ? 51 : 0;
            rcv_idle = (phase == 0) ? 51 : (phase == 1) ? 18 : 0;
            for (int k = 0; k < NUM_RAND / 3; k++) begin
                // long output stall while requests keep coming
                if (phase == 2 && k == 100)
                    hold_go = 1'b1;
                send_request(random_pair(), 0, none);
            end
        end

        i_s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (angle_q.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (angle_q.size() != 0) begin
            mismatches += angle_q.size();
            $display("%0d results never arrived", angle_q.size());
        end
        $display("checked %0d results (%0d degenerate), %0d mismatches",
                 results_seen, degen_seen, mismatches);
        $display("covered directed extremes, quarter turns, zero-length sides and a %0d-cycle stall",
                 HOLD_LEN);
        if (mismatches == 0) begin
            $display("relative_quaternion_to_euler_top regression: pass");
        end else begin
            $display("relative_quaternion_to_euler_top regression: fail");
        end
        $finish;
    end

endmodule
